### rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// shared constants, codes and types of the flash sector length store
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int NUM_SECTORS       = 4096;
    localparam int SECTORS_PER_BLOCK = 32;
    localparam int SECTOR_BYTES      = 512;

    localparam int SECTOR_W  = $clog2(NUM_SECTORS);
    localparam int COUNT_W   = SECTOR_W + 1;
    localparam int BLK_SHIFT = $clog2(SECTORS_PER_BLOCK);
    localparam int BLOCK_W   = 7;
    localparam int LEN_W     = 10;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;

    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ERASE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOALLOC  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DECLINED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [SECTOR_W-1:0] sector_index;
        logic [BLOCK_W-1:0]  block_index;
        logic [LEN_W-1:0]    data_length;
        logic                overwrite_ok;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [SECTOR_W-1:0] sector;
        logic [LEN_W-1:0]    length;
    } result_t;

endpackage

### rtl/fss_ram.sv
// ----------------------------------------------------------------------------
// fss_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module fss_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/fss_ctrl.sv
// ----------------------------------------------------------------------------
// fss_ctrl
// sequencer: clearing pass, lookup, relocation search, block erase
// ----------------------------------------------------------------------------
module fss_ctrl
    import fss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  count,
    input  logic                in_valid,
    output logic                in_stall,
    input  item_t               item,
    output logic                res_valid,
    input  logic                res_free,
    output result_t             res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_LOOK   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_ERASE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [SECTOR_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  d_reg, d_next;
    logic                phase_reg, phase_next;
    logic                pend_reg, pend_next;
    logic [SECTOR_W-1:0] pend_addr_reg, pend_addr_next;
    item_t               req_reg, req_next;
    result_t             res_reg, res_next;

    logic                ram_we;
    logic [SECTOR_W-1:0] ram_addr;
    logic [LEN_W-1:0]    ram_wdata;
    logic [LEN_W-1:0]    ram_rdata;

    logic [LEN_W-1:0]    len_clamp;
    logic [COUNT_W-1:0]  up_sum;
    logic                up_ok;
    logic                dn_ok;
    logic [SECTOR_W-1:0] dn_addr;
    logic [SECTOR_W-1:0] first;

    fss_ram #(
        .DEPTH (NUM_SECTORS),
        .WIDTH (LEN_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    assign len_clamp = (req_reg.data_length > LEN_W'(SECTOR_BYTES)) ?
                       LEN_W'(SECTOR_BYTES) : req_reg.data_length;
    assign up_sum    = COUNT_W'(req_reg.sector_index) + d_reg;
    assign up_ok     = (up_sum < count);
    assign dn_ok     = (d_reg <= COUNT_W'(req_reg.sector_index));
    assign dn_addr   = req_reg.sector_index - d_reg[SECTOR_W-1:0];
    assign first     = SECTOR_W'(req_reg.block_index) << BLK_SHIFT;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        d_next         = d_reg;
        phase_next     = phase_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_addr       = req_reg.sector_index;
        ram_wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                ram_addr = item.sector_index;
                if (in_valid)
                begin
                    req_next   = item;
                    cnt_next   = '0;
                    state_next = S_DONE;
                    case (item.req_type)
                        REQ_READ, REQ_WRITE:
                        begin
                            res_next = '{STAT_NOALLOC, item.sector_index, '0};
                            if (count == '0)
                            begin
                                res_next.status = STAT_NOALLOC;
                            end
                            else if (COUNT_W'(item.sector_index) >= count)
                            begin
                                res_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                state_next = S_LOOK;
                            end
                        end
                        REQ_ERASE:
                        begin
                            res_next = '{STAT_NOALLOC,
                                         SECTOR_W'(item.block_index) << BLK_SHIFT, '0};
                            if (count == '0)
                            begin
                                res_next.status = STAT_NOALLOC;
                            end
                            else if (COUNT_W'(item.block_index) >= (count >> BLK_SHIFT))
                            begin
                                res_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                res_next.status = STAT_OK;
                                state_next      = S_ERASE;
                            end
                        end
                        default:
                        begin
                            res_next = '{STAT_OK, '0, '0};
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOOK:
            begin
                state_next = S_DONE;
                if (req_reg.req_type == REQ_READ)
                begin
                    res_next = '{STAT_OK, req_reg.sector_index, ram_rdata};
                end
                else if (ram_rdata == '0)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = len_clamp;
                    res_next  = '{STAT_OK, req_reg.sector_index, len_clamp};
                end
                else if (!req_reg.overwrite_ok)
                begin
                    res_next = '{STAT_DECLINED, req_reg.sector_index, ram_rdata};
                end
                else
                begin
                    state_next = S_SEARCH;
                    d_next     = COUNT_W'(1);
                    phase_next = 1'b0;
                    pend_next  = 1'b0;
                end
            end
            S_SEARCH:
            begin
                if (pend_reg && (ram_rdata == '0))
                begin
                    ram_we     = 1'b1;
                    ram_addr   = pend_addr_reg;
                    ram_wdata  = len_clamp;
                    res_next   = '{STAT_OK, pend_addr_reg, len_clamp};
                    state_next = S_DONE;
                end
                else if (!phase_reg && !up_ok && !dn_ok)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = len_clamp;
                    res_next   = '{STAT_OK, req_reg.sector_index, len_clamp};
                    state_next = S_DONE;
                end
                else if (!phase_reg)
                begin
                    ram_addr       = up_sum[SECTOR_W-1:0];
                    pend_next      = up_ok;
                    pend_addr_next = up_sum[SECTOR_W-1:0];
                    phase_next     = 1'b1;
                end
                else
                begin
                    ram_addr       = dn_addr;
                    pend_next      = dn_ok;
                    pend_addr_next = dn_addr;
                    phase_next     = 1'b0;
                    d_next         = d_reg + 1'b1;
                end
            end
            S_ERASE:
            begin
                ram_we   = 1'b1;
                ram_addr = first + SECTOR_W'(cnt_reg[BLK_SHIFT-1:0]);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[BLK_SHIFT-1:0] == '1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            state_next = S_CLEAR;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            d_reg     <= '0;
            phase_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            d_reg     <= d_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        req_reg       <= req_next;
        res_reg       <= res_next;
    end

`ifndef SYNTHESIS
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == S_CLEAR) && (cnt_reg == '0))
        else $error("configuration write did not start a clearing pass");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (d_reg <= count))
        else $error("relocation distance beyond sector count");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg != S_CLEAR)) |-> (COUNT_W'(ram_addr) < count))
        else $error("store write outside active sectors");

    a_error_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (res_reg.status != STAT_OK)
            && (res_reg.status != STAT_DECLINED)) |-> (res_reg.length == '0))
        else $error("error result carries a length");
`endif

endmodule

### rtl/flash_sector_store_with_relocation.sv
// path to the output register: read, direct or declined write via the lookup state; error or
// unused request straight to done; relocated write via lookup and search; erase via erase
// flow: one transaction at a time, next input accepted once the result moves to the output register
// reset: a clearing pass over every sector of the store follows reset and every sector_count
// write; in_stall stays high during that pass; sector_count resets to 0.
// ----------------------------------------------------------------------------
// flash_sector_store_with_relocation
// per-sector length store with relocation of writes to occupied sectors
// ----------------------------------------------------------------------------
module flash_sector_store_with_relocation
    import fss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [SECTOR_W-1:0] sector_index,
    input  logic [BLOCK_W-1:0]  block_index,
    input  logic [LEN_W-1:0]    data_length,
    input  logic                overwrite_ok,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STAT_W-1:0]   status,
    output logic [SECTOR_W-1:0] sector_used,
    output logic [LEN_W-1:0]    stored_length,
    output logic                sector_valid
);

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_act;
    item_t               item;
    logic                res_valid;
    logic                res_free;
    result_t             res;

    logic                out_valid_reg;
    result_t             out_reg;

    assign count_act = (count_reg > COUNT_W'(NUM_SECTORS)) ?
                       COUNT_W'(NUM_SECTORS) : count_reg;

    assign item = '{req_type, sector_index, block_index, data_length, overwrite_ok};

    assign res_free = !out_valid_reg || !out_stall;

    fss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .count     (count_act),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .item      (item),
        .res_valid (res_valid),
        .res_free  (res_free),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            if (res_valid && res_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_free)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign sector_used   = out_reg.sector;
    assign stored_length = out_reg.length;
    assign sector_valid  = (out_reg.length != '0);

endmodule
